[src/assert_macros.svh]
// Assertion macros used by the RTL of the matrix minimax block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, prop, msg)
`endif
`endif

[src/mmm_pkg.sv]
// Package for the matrix minimax / maximin block: widths, types.
// No dependencies.
`default_nettype none
package mmm_pkg;
  localparam int MAX_DIM = 16;
  localparam int DATA_W  = 16;
  localparam int DIM_W   = 5;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW      = (DIM_W > IDX_W + 1) ? DIM_W : IDX_W + 1;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic             first_row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } s1_ctl_t;
endpackage
`default_nettype wire

[src/matrix_minimax_maximin.sv]
// Streaming minimax / maximin of an n-by-n matrix, one word per cycle unless output stalls.
// Throughput: one element per cycle unless the output stalls; one-deep forwarding on the
// column-maxima RAM read-modify-write; the result is registered after stage 1.
// Reset (rst, synchronous): clears counters, valids and sets dimension to 3;
// the column-maxima RAM and the running extremes are not cleared.
// Depends on mmm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module matrix_minimax_maximin
  import mmm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [DIM_W-1:0]    cfg_wdata,    // dimension
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic signed [15:0]  s_tdata,      // [15:0] element
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata       // [15:0] min_of_col_max, [31:16] max_of_row_min
);

  logic [DIM_W-1:0] dimension;
  logic [IDX_W-1:0] col_index, col_index_next;
  logic [IDX_W-1:0] row_index, row_index_next;
  logic [NW-1:0]    n_eff;
  logic             last_col, last_row, accept;

  elem_t            col_max_mem [MAX_DIM];
  elem_t            rd_data;
  logic             fwd_hit;
  elem_t            fwd_data;

  logic             s1_valid;
  s1_ctl_t          s1;
  elem_t            s1_elem;
  logic             s1_emit, s1_go;

  elem_t            current_row_min, best_row_min, least_col_max;
  elem_t            col_old, cm, row_min_new, best_new, least_new;

  always_comb begin
    if (dimension == '0) begin
      n_eff = NW'(1);
    end else if (NW'(dimension) > NW'(MAX_DIM)) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(dimension);
    end
    last_col = (NW'(col_index) + NW'(1)) >= n_eff;
    last_row = (NW'(row_index) + NW'(1)) >= n_eff;
    col_index_next = last_col ? '0 : col_index + IDX_W'(1);
    if (!last_col) begin
      row_index_next = row_index;
    end else if (last_row) begin
      row_index_next = '0;
    end else begin
      row_index_next = row_index + IDX_W'(1);
    end
  end

  assign s1_emit  = s1.last_col && s1.last_row;
  assign s1_go    = s1_valid && !(s1_emit && m_tvalid && !m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    col_old     = fwd_hit ? fwd_data : rd_data;
    cm          = (s1.first_row || s1_elem > col_old) ? s1_elem : col_old;
    row_min_new = (s1.first_col || s1_elem < current_row_min) ? s1_elem : current_row_min;
    least_new   = least_col_max;
    if (s1.last_row && (s1.first_col || cm < least_col_max)) begin
      least_new = cm;
    end
    best_new = best_row_min;
    if (s1.last_col && (s1.first_row || row_min_new > best_row_min)) begin
      best_new = row_min_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_wen) begin
      dimension <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        col_index <= col_index_next;
        row_index <= row_index_next;
        fwd_hit   <= s1_go && (s1.col == col_index);
      end else if (s1_go) begin
        fwd_hit   <= 1'b0;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // column maxima RAM: read on accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (s1_go) begin
      col_max_mem[s1.col] <= cm;
    end
    if (accept) begin
      rd_data <= col_max_mem[col_index];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data     <= cm;
      s1_elem      <= s_tdata;
      s1.col       <= col_index;
      s1.first_row <= (row_index == '0);
      s1.first_col <= (col_index == '0);
      s1.last_col  <= last_col;
      s1.last_row  <= last_row;
    end
    if (s1_go) begin
      current_row_min <= row_min_new;
      best_row_min    <= best_new;
      least_col_max   <= least_new;
    end
    if (s1_go && s1_emit) begin
      m_tdata <= {best_new, least_new};
    end
  end

  `ASSERT_AT(a_result_from_last, clk, rst,
    $rose(m_tvalid) |-> $past(s1_go && s1.last_col && s1.last_row), "result without last element")
  `ASSERT_AT(a_fwd_needs_stage, clk, rst, fwd_hit |-> s1_valid, "forward flag with empty stage")
  `ASSERT_AT(a_counters_wrap, clk, rst,
    (accept && last_col && last_row) |=> (row_index == '0 && col_index == '0),
    "counters did not restart")
  `ASSERT_NEVER(a_stall_cause, clk, rst, !s_tready && !(m_tvalid && !m_tready),
    "input stalled without output back-pressure")

endmodule
`default_nettype wire

[tb/mmm_checker.sv]
// Checker for matrix_minimax_maximin: follows the dimension register and the element
// stream, predicts each minimax / maximin result word and compares it on the output.
// Depends on mmm_pkg.
module mmm_checker
  import mmm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [DIM_W-1:0]   cfg_wdata,
  input  wire logic               s_tvalid,
  input  wire logic               s_tready,
  input  wire logic signed [15:0] s_tdata,
  input  wire logic               m_tvalid,
  input  wire logic               m_tready,
  input  wire logic [31:0]        m_tdata,
  output int                      failures,
  output int                      outstanding
);

  typedef struct packed {
    elem_t maximin;  // [31:16]
    elem_t minimax;  // [15:0]
  } saddle_t;

  saddle_t          saddle_q[$];
  logic [DIM_W-1:0] dim_reg;
  elem_t            col_peak [MAX_DIM];
  elem_t            row_floor;
  elem_t            best_floor;
  elem_t            least_peak;
  int               row_at;
  int               col_at;
  int               fail_count = 0;

  task automatic fold_element(input elem_t v);
    int    n;
    int    c;
    bit    in_last_col;
    bit    in_last_row;
    elem_t peak;
    n = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    c = col_at;
    in_last_col = (c + 1 >= n);
    in_last_row = (row_at + 1 >= n);
    if (c >= MAX_DIM) c = MAX_DIM - 1;
    if (row_at == 0 || v > col_peak[c]) col_peak[c] = v;
    peak = col_peak[c];
    if (c == 0 || v < row_floor) row_floor = v;
    if (in_last_row && (c == 0 || peak < least_peak)) least_peak = peak;
    if (!in_last_col) begin
      col_at = c + 1;
    end else begin
      if (row_at == 0 || row_floor > best_floor) best_floor = row_floor;
      col_at = 0;
      if (!in_last_row) begin
        row_at = row_at + 1;
      end else begin
        row_at = 0;
        saddle_q.push_back('{maximin: best_floor, minimax: least_peak});
      end
    end
  endtask

  always @(posedge clk) begin
    saddle_t got;
    saddle_t want;
    if (rst) begin
      dim_reg = DIM_RESET;
      row_at = 0;
      col_at = 0;
      saddle_q.delete();
    end else begin
      if (cfg_wen) dim_reg = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got = saddle_t'(m_tdata);
        if (saddle_q.size() == 0) begin
          fail_count++;
          $display("%0t mmm_checker: result word %h with none expected", $time, m_tdata);
        end else begin
          want = saddle_q.pop_front();
          if (got.minimax !== want.minimax) begin
            fail_count++;
            $display("%0t mmm_checker: minimax expected %0d got %0d", $time,
                     $signed(want.minimax), $signed(got.minimax));
          end
          if (got.maximin !== want.maximin) begin
            fail_count++;
            $display("%0t mmm_checker: maximin expected %0d got %0d", $time,
                     $signed(want.maximin), $signed(got.maximin));
          end
        end
      end
      if (s_tvalid && s_tready) fold_element(elem_t'(s_tdata));
    end
    outstanding <= saddle_q.size();
    failures    <= fail_count;
  end

endmodule

[tb/tb_top.sv]
// Top of the matrix_minimax_maximin testbench: clock, reset, dimension writes,
// element stream and output back-pressure; the verdict comes from mmm_checker.
// Depends on mmm_pkg, mmm_checker and the block itself.
module tb_top;
  import mmm_pkg::*;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_wen   = 1'b0;
  logic [DIM_W-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  elem_t            s_tdata   = '0;
  logic             m_tready  = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire [31:0]       m_tdata;

  int failures;
  int outstanding;
  int sent       = 0;
  int tx_gap_pct = 0;
  int rx_gap_pct = 0;
  bit hold_ask   = 1'b0;

  always #4 clk = ~clk;

  matrix_minimax_maximin dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  mmm_checker saddle_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  function automatic elem_t draw_element();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return elem_t'(int'($urandom_range(0, 8)) - 4);
      default: return elem_t'($urandom());
    endcase
  endfunction

  task automatic push_element(input elem_t v);
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // only once the block has drained, also mid-matrix
  task automatic set_dimension(input logic [DIM_W-1:0] d);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic send_matrices(input int n, input int count);
    repeat (count * n * n) push_element(draw_element());
  endtask

  initial begin
    forever begin
      if (hold_ask) begin
        hold_ask <= 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    elem_t            corner_vals [9];
    int               phase;
    int               n;
    int               pick;
    bit               pressed;
    logic [DIM_W-1:0] d;
    corner_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                    16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000};
    pressed = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_gap_pct = 20;
    rx_gap_pct = 20;
    // reset dimension of three, extremes of the element range
    foreach (corner_vals[i]) push_element(corner_vals[i]);
    // one-by-one matrices, zero treated as one, then a two-by-two of 0x8000
    set_dimension(5'd1);
    push_element(16'sh7FFF);
    push_element(16'sh8000);
    set_dimension(5'd0);
    push_element(16'sh5555);
    set_dimension(5'd2);
    repeat (4) push_element(16'sh8000);
    // lowered between rows: row one becomes the last
    set_dimension(5'd3);
    repeat (3) push_element(draw_element());
    set_dimension(5'd2);
    repeat (2) push_element(draw_element());
    // lowered inside row zero
    set_dimension(5'd4);
    repeat (3) push_element(draw_element());
    set_dimension(5'd2);
    repeat (3) push_element(draw_element());

    phase = 0;
    while (sent < 1600) begin
      if (!pressed && sent > 800) begin
        // stall the output long enough for the block to back up
        pressed = 1'b1;
        set_dimension(5'd1);
        tx_gap_pct = 0;
        hold_ask <= 1'b1;
        send_matrices(1, 60);
      end
      tx_gap_pct = $urandom_range(0, 2) * 15;
      rx_gap_pct = $urandom_range(0, 2) * 15;
      pick = $urandom_range(0, 9);
      if (phase == 2) d = 5'd16;
      else if (phase == 7) d = DIM_W'($urandom_range(17, 31));
      else if (pick == 0) d = DIM_W'($urandom_range(6, 15));
      else if (pick == 1) d = 5'd0;
      else d = DIM_W'($urandom_range(1, 5));
      n = (d == 0) ? 1 : (d > MAX_DIM) ? MAX_DIM : int'(d);
      set_dimension(d);
      send_matrices(n, (n > 6) ? 1 : $urandom_range(2, 8));
      phase++;
    end

    tx_gap_pct = 0;
    rx_gap_pct = 0;
    set_dimension(5'd3);
    send_matrices(3, 16);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[matrix_minimax_maximin.f]
+incdir+src
src/mmm_pkg.sv
src/matrix_minimax_maximin.sv
tb/mmm_checker.sv
tb/tb_top.sv
